// ----- hdl/hsvc_pkg.sv -----
`default_nettype none
package hsvc_pkg;

  localparam int unsigned HUE_W   = 9;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned FRAC_W  = 6;
  localparam int unsigned PROD_W  = 14;
  localparam int unsigned NUM_W   = 20;
  localparam int unsigned SCL_W   = 24;
  localparam int unsigned EST_W   = 9;
  localparam int unsigned RECIP_W = 33;

  localparam logic [HUE_W-1:0]   HUE_FULL   = 9'd360;
  localparam logic [HUE_W-1:0]   SECTOR_DEG = 9'd60;
  localparam logic [PCT_W-1:0]   PCT_FULL   = 7'd100;
  localparam logic [EST_W-1:0]   CHAN_MAX   = 9'd255;

  // channel = floor(n * 255 / 600000) = floor(n * 17 / 40000)
  localparam logic [SCL_W-1:0]   DIV_DEN     = 24'd40000;
  localparam logic [RECIP_W-1:0] RECIP_MUL   = 33'd419;
  localparam int unsigned        RECIP_SHIFT = 24;
  localparam logic [NUM_W-1:0]   FULL_MUL    = 20'd6000;

  typedef logic [2:0] sector_t;

  localparam sector_t SECT_RY = 3'd0;
  localparam sector_t SECT_YG = 3'd1;
  localparam sector_t SECT_GC = 3'd2;
  localparam sector_t SECT_CB = 3'd3;
  localparam sector_t SECT_BM = 3'd4;
  localparam sector_t SECT_MR = 3'd5;

  typedef struct packed {
    logic [HUE_W-1:0] hue_deg;
    logic [PCT_W-1:0] sat_pct;
    logic [PCT_W-1:0] val_pct;
  } hsvc_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } hsvc_out_t;

  // channel numerators scaled by 600000
  typedef struct packed {
    sector_t          sector;
    logic [NUM_W-1:0] n_full;
    logic [NUM_W-1:0] n_zero;
    logic [NUM_W-1:0] n_mid;
  } hsvc_terms_t;

  function automatic logic [HUE_W-1:0] sector_base(input sector_t sec);
    logic [HUE_W-1:0] base;
    case (sec)
      SECT_RY: base = 9'd0;
      SECT_YG: base = 9'd60;
      SECT_GC: base = 9'd120;
      SECT_CB: base = 9'd180;
      SECT_BM: base = 9'd240;
      SECT_MR: base = 9'd300;
      default: base = 9'd0;
    endcase
    return base;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/hsvc_front.sv -----
`default_nettype none
module hsvc_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_vld,
  output logic                       in_rdy,
  input  wire hsvc_pkg::hsvc_in_t    in_data,
  output logic                       out_vld,
  input  wire logic                  out_rdy,
  output hsvc_pkg::hsvc_terms_t      out_terms
);

  logic [2:0] vld_r;
  logic [2:0] adv;

  hsvc_pkg::sector_t                 s1_sec_r;
  logic [hsvc_pkg::FRAC_W-1:0]       s1_frac_r;
  logic [hsvc_pkg::PCT_W-1:0]        s1_sat_r;
  logic [hsvc_pkg::PCT_W-1:0]        s1_val_r;

  hsvc_pkg::sector_t                 s2_sec_r;
  logic [hsvc_pkg::FRAC_W-1:0]       s2_frac_r;
  logic [hsvc_pkg::PROD_W-1:0]       s2_vs_r;
  logic [hsvc_pkg::PROD_W-1:0]       s2_vns_r;
  logic [hsvc_pkg::PCT_W-1:0]        s2_val_r;

  hsvc_pkg::hsvc_terms_t             s3_terms_r;

  logic [hsvc_pkg::HUE_W-1:0]        hue_red;
  hsvc_pkg::sector_t                 sec_nxt;
  logic [hsvc_pkg::HUE_W-1:0]        frac_wide;
  logic [hsvc_pkg::PCT_W-1:0]        sat_nxt;
  logic [hsvc_pkg::PCT_W-1:0]        val_nxt;
  logic [hsvc_pkg::FRAC_W-1:0]       frac_eff_nxt;
  logic [hsvc_pkg::NUM_W-1:0]        x_term;
  logic [hsvc_pkg::NUM_W-1:0]        m_term;
  hsvc_pkg::hsvc_terms_t             terms_nxt;

  assign adv[2]    = !vld_r[2] || out_rdy;
  assign adv[1]    = !vld_r[1] || adv[2];
  assign adv[0]    = !vld_r[0] || adv[1];
  assign in_rdy    = adv[0];
  assign out_vld   = vld_r[2];
  assign out_terms = s3_terms_r;

  // hue reduction, sector search, input clamping
  always_comb begin
    hue_red = (in_data.hue_deg >= hsvc_pkg::HUE_FULL) ?
              in_data.hue_deg - hsvc_pkg::HUE_FULL : in_data.hue_deg;
    if (hue_red >= 9'd300) begin
      sec_nxt = hsvc_pkg::SECT_MR;
    end else if (hue_red >= 9'd240) begin
      sec_nxt = hsvc_pkg::SECT_BM;
    end else if (hue_red >= 9'd180) begin
      sec_nxt = hsvc_pkg::SECT_CB;
    end else if (hue_red >= 9'd120) begin
      sec_nxt = hsvc_pkg::SECT_GC;
    end else if (hue_red >= hsvc_pkg::SECTOR_DEG) begin
      sec_nxt = hsvc_pkg::SECT_YG;
    end else begin
      sec_nxt = hsvc_pkg::SECT_RY;
    end
    frac_wide = hue_red - hsvc_pkg::sector_base(sec_nxt);
    sat_nxt = (in_data.sat_pct > hsvc_pkg::PCT_FULL) ? hsvc_pkg::PCT_FULL : in_data.sat_pct;
    val_nxt = (in_data.val_pct > hsvc_pkg::PCT_FULL) ? hsvc_pkg::PCT_FULL : in_data.val_pct;
  end

  // odd sectors run the ramp downward
  assign frac_eff_nxt = s1_sec_r[0] ?
                        hsvc_pkg::SECTOR_DEG[hsvc_pkg::FRAC_W-1:0] - s1_frac_r : s1_frac_r;

  always_comb begin
    x_term = hsvc_pkg::NUM_W'(s2_vs_r) * hsvc_pkg::NUM_W'(s2_frac_r);
    m_term = hsvc_pkg::NUM_W'(s2_vns_r) * hsvc_pkg::NUM_W'(hsvc_pkg::SECTOR_DEG);
    terms_nxt.sector = s2_sec_r;
    terms_nxt.n_full = hsvc_pkg::NUM_W'(s2_val_r) * hsvc_pkg::FULL_MUL;
    terms_nxt.n_zero = m_term;
    terms_nxt.n_mid  = x_term + m_term;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_vld;
      if (adv[1]) vld_r[1] <= vld_r[0];
      if (adv[2]) vld_r[2] <= vld_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_sec_r  <= sec_nxt;
      s1_frac_r <= frac_wide[hsvc_pkg::FRAC_W-1:0];
      s1_sat_r  <= sat_nxt;
      s1_val_r  <= val_nxt;
    end
    if (adv[1]) begin
      s2_sec_r  <= s1_sec_r;
      s2_frac_r <= frac_eff_nxt;
      s2_vs_r   <= hsvc_pkg::PROD_W'(s1_val_r) * hsvc_pkg::PROD_W'(s1_sat_r);
      s2_vns_r  <= hsvc_pkg::PROD_W'(s1_val_r) *
                   hsvc_pkg::PROD_W'(hsvc_pkg::PCT_FULL - s1_sat_r);
      s2_val_r  <= s1_val_r;
    end
    if (adv[2]) begin
      s3_terms_r <= terms_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/hsvc_scale.sv -----
`default_nettype none
module hsvc_scale (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_vld,
  output logic                       in_rdy,
  input  wire hsvc_pkg::hsvc_terms_t in_terms,
  output logic                       out_vld,
  input  wire logic                  out_rdy,
  output hsvc_pkg::hsvc_out_t        out_data
);

  logic [2:0] vld_r;
  logic [2:0] adv;

  logic [hsvc_pkg::NUM_W-1:0]   num  [3];
  logic [hsvc_pkg::SCL_W-1:0]   s1_p_r  [3];
  logic [hsvc_pkg::SCL_W-1:0]   s2_p_r  [3];
  logic [hsvc_pkg::EST_W-1:0]   s2_qe_r [3];
  logic [hsvc_pkg::RECIP_W-1:0] recip   [3];
  logic [hsvc_pkg::SCL_W-1:0]   rem     [3];
  logic [hsvc_pkg::EST_W-1:0]   q_fix   [3];
  logic [hsvc_pkg::CHAN_W-1:0]  chan    [3];
  hsvc_pkg::hsvc_out_t          out_r;

  assign adv[2]   = !vld_r[2] || out_rdy;
  assign adv[1]   = !vld_r[1] || adv[2];
  assign adv[0]   = !vld_r[0] || adv[1];
  assign in_rdy   = adv[0];
  assign out_vld  = vld_r[2];
  assign out_data = out_r;

  // sector picks where the full, zero and ramp terms go
  always_comb begin
    case (in_terms.sector)
      hsvc_pkg::SECT_RY: begin
        num[0] = in_terms.n_full; num[1] = in_terms.n_mid;  num[2] = in_terms.n_zero;
      end
      hsvc_pkg::SECT_YG: begin
        num[0] = in_terms.n_mid;  num[1] = in_terms.n_full; num[2] = in_terms.n_zero;
      end
      hsvc_pkg::SECT_GC: begin
        num[0] = in_terms.n_zero; num[1] = in_terms.n_full; num[2] = in_terms.n_mid;
      end
      hsvc_pkg::SECT_CB: begin
        num[0] = in_terms.n_zero; num[1] = in_terms.n_mid;  num[2] = in_terms.n_full;
      end
      hsvc_pkg::SECT_BM: begin
        num[0] = in_terms.n_mid;  num[1] = in_terms.n_zero; num[2] = in_terms.n_full;
      end
      default: begin
        num[0] = in_terms.n_full; num[1] = in_terms.n_zero; num[2] = in_terms.n_mid;
      end
    endcase
  end

  // reciprocal estimate is exact or one low, the remainder check fixes it
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      recip[i] = hsvc_pkg::RECIP_W'(s1_p_r[i]) * hsvc_pkg::RECIP_MUL;
      rem[i]   = s2_p_r[i] - hsvc_pkg::SCL_W'(s2_qe_r[i]) * hsvc_pkg::DIV_DEN;
      q_fix[i] = s2_qe_r[i] + ((rem[i] >= hsvc_pkg::DIV_DEN) ? 9'd1 : 9'd0);
      chan[i]  = (q_fix[i] > hsvc_pkg::CHAN_MAX) ?
                 hsvc_pkg::CHAN_MAX[hsvc_pkg::CHAN_W-1:0] : q_fix[i][hsvc_pkg::CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_vld;
      if (adv[1]) vld_r[1] <= vld_r[0];
      if (adv[2]) vld_r[2] <= vld_r[1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (adv[0]) begin
        s1_p_r[i] <= {num[i], 4'b0000} + hsvc_pkg::SCL_W'(num[i]);
      end
      if (adv[1]) begin
        s2_p_r[i]  <= s1_p_r[i];
        s2_qe_r[i] <= recip[i][hsvc_pkg::RECIP_SHIFT +: hsvc_pkg::EST_W];
      end
    end
    if (adv[2]) begin
      out_r.red   <= chan[0];
      out_r.green <= chan[1];
      out_r.blue  <= chan[2];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/hsv_to_rgb_converter_unit.sv -----
`default_nettype none
// HSV to RGB converter. Takes a hue in degrees (360..511 wraps by 360) and
// saturation and value in percent (above 100 clamps to 100), and returns
// 8-bit red, green and blue, each floor(255 * channel) computed exactly.
// One pixel enters per clock while in_stall is low; in its pipeline, three
// stages build the channel numerators (hue sector, small products, sums),
// three scale them to 8 bits by a reciprocal multiply and a remainder fix.
// Every stage advances on its own, so bubbles close up and out_stall backs
// up to in_stall only once the pipeline is full.
module hsv_to_rgb_converter_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire hsvc_pkg::hsvc_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output hsvc_pkg::hsvc_out_t      out_data
);

  logic                  front_rdy;
  logic                  terms_vld;
  logic                  terms_rdy;
  logic                  scale_vld;
  hsvc_pkg::hsvc_terms_t terms;

  assign in_stall  = !front_rdy;
  assign out_valid = scale_vld;

  hsvc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (in_valid),
    .in_rdy    (front_rdy),
    .in_data   (in_data),
    .out_vld   (terms_vld),
    .out_rdy   (terms_rdy),
    .out_terms (terms)
  );

  hsvc_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (terms_vld),
    .in_rdy   (terms_rdy),
    .in_terms (terms),
    .out_vld  (scale_vld),
    .out_rdy  (!out_stall),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SCALE_DEN     = 600000;
  localparam int unsigned MAX_SHOWN     = 10;
  localparam int unsigned RANDOM_PIXELS = 1025;
  localparam int unsigned DRAIN_CYCLES  = 12;

  class color_scoreboard;
    hsvc_pkg::hsvc_out_t pending_colors[$];
    int unsigned         mismatches;

    function new();
      mismatches = 0;
    endfunction

    function logic [hsvc_pkg::CHAN_W-1:0] to_channel(int unsigned num);
      int unsigned q;
      q = num * hsvc_pkg::CHAN_MAX / SCALE_DEN;
      if (q > hsvc_pkg::CHAN_MAX) q = hsvc_pkg::CHAN_MAX;
      return q[hsvc_pkg::CHAN_W-1:0];
    endfunction

    function hsvc_pkg::hsvc_out_t predict_color(hsvc_pkg::hsvc_in_t px);
      int unsigned         hue, sat, val, frac, chroma, floor_term, mid;
      int unsigned         r, g, b;
      hsvc_pkg::sector_t   sect;
      hsvc_pkg::hsvc_out_t col;
      hue = px.hue_deg;
      sat = px.sat_pct;
      val = px.val_pct;
      if (hue >= hsvc_pkg::HUE_FULL) hue = hue - hsvc_pkg::HUE_FULL;
      if (sat > hsvc_pkg::PCT_FULL) sat = hsvc_pkg::PCT_FULL;
      if (val > hsvc_pkg::PCT_FULL) val = hsvc_pkg::PCT_FULL;
      sect       = hsvc_pkg::sector_t'(hue / hsvc_pkg::SECTOR_DEG);
      frac       = hue % hsvc_pkg::SECTOR_DEG;
      chroma     = hsvc_pkg::SECTOR_DEG * val * sat;
      floor_term = hsvc_pkg::SECTOR_DEG * val * (hsvc_pkg::PCT_FULL - sat);
      mid        = sect[0] ? val * sat * (hsvc_pkg::SECTOR_DEG - frac) :
                             val * sat * frac;
      case (sect)
        hsvc_pkg::SECT_RY: begin r = chroma; g = mid;    b = 0;      end
        hsvc_pkg::SECT_YG: begin r = mid;    g = chroma; b = 0;      end
        hsvc_pkg::SECT_GC: begin r = 0;      g = chroma; b = mid;    end
        hsvc_pkg::SECT_CB: begin r = 0;      g = mid;    b = chroma; end
        hsvc_pkg::SECT_BM: begin r = mid;    g = 0;      b = chroma; end
        default:           begin r = chroma; g = 0;      b = mid;    end
      endcase
      col.red   = to_channel(r + floor_term);
      col.green = to_channel(g + floor_term);
      col.blue  = to_channel(b + floor_term);
      return col;
    endfunction

    function void note_pixel(hsvc_pkg::hsvc_in_t px);
      pending_colors.push_back(predict_color(px));
    endfunction

    function void check_color(hsvc_pkg::hsvc_out_t got);
      hsvc_pkg::hsvc_out_t want;
      if (pending_colors.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected color transfer: rgb %0d %0d %0d",
                   got.red, got.green, got.blue);
        return;
      end
      want = pending_colors.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("color mismatch: expected rgb %0d %0d %0d, got %0d %0d %0d",
                   want.red, want.green, want.blue, got.red, got.green, got.blue);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  hsvc_pkg::hsvc_in_t  in_data;
  logic                out_valid;
  logic                out_stall;
  hsvc_pkg::hsvc_out_t out_data;
  bit                  steady;

  color_scoreboard board = new();

  int unsigned corner_hsv [0:24][0:2] = '{
    '{0, 100, 100},   '{60, 100, 100},  '{120, 100, 100}, '{180, 100, 100},
    '{240, 100, 100}, '{300, 100, 100}, '{359, 100, 100}, '{360, 100, 100},
    '{511, 127, 127}, '{0, 0, 0},       '{0, 0, 100},     '{30, 100, 100},
    '{59, 100, 100},  '{61, 100, 100},  '{90, 50, 50},    '{119, 75, 80},
    '{150, 100, 100}, '{210, 33, 67},   '{270, 100, 100}, '{330, 100, 100},
    '{359, 101, 100}, '{420, 100, 101}, '{200, 127, 64},  '{100, 1, 1},
    '{299, 99, 99}
  };

  hsv_to_rgb_converter_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic send_pixel(input hsvc_pkg::hsvc_in_t px);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall !== 1'b0);
    board.note_pixel(px);
  endtask

  function automatic hsvc_pkg::hsvc_in_t random_pixel();
    hsvc_pkg::hsvc_in_t px;
    if ($urandom_range(0, 4) != 0) begin
      px.hue_deg = hsvc_pkg::HUE_W'($urandom_range(0, 359));
      px.sat_pct = hsvc_pkg::PCT_W'($urandom_range(0, 100));
      px.val_pct = hsvc_pkg::PCT_W'($urandom_range(0, 100));
    end else begin
      px.hue_deg = hsvc_pkg::HUE_W'($urandom_range(0, 511));
      px.sat_pct = hsvc_pkg::PCT_W'($urandom_range(0, 127));
      px.val_pct = hsvc_pkg::PCT_W'($urandom_range(0, 127));
    end
    return px;
  endfunction

  initial begin
    hsvc_pkg::hsvc_in_t px;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    steady   = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < 25; i++) begin
      px.hue_deg = hsvc_pkg::HUE_W'(corner_hsv[i][0]);
      px.sat_pct = hsvc_pkg::PCT_W'(corner_hsv[i][1]);
      px.val_pct = hsvc_pkg::PCT_W'(corner_hsv[i][2]);
      send_pixel(px);
    end
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if (i % 64 == 0) steady = ($urandom_range(0, 3) == 0);
      send_pixel(random_pixel());
    end
    in_valid <= 1'b0;
    while (board.pending_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending_colors.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    int unsigned hold;
    hold      = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        board.check_color(out_data);
        hold = steady ? 0 : $urandom_range(0, 3);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire
